FILE: sv/assert_macros.svh
// Assertion macros used by the converter's top-level core.
// No dependencies; the includer supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ECAL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ECAL_ASSERT_NOT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/ecal_pkg.sv
// Package for the epoch to local calendar converter: constants, microcode
// opcodes and the control store. No dependencies.
package ecal_pkg;

    localparam int unsigned PC_W = 4;
    localparam int unsigned DIV_CNT_W = 1;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 1'b1;

    localparam logic [11:0] BASE_YEAR = 12'd1970;
    localparam logic [31:0] BASE_WEEKDAY = 32'd4;
    localparam logic [6:0] BASE_C100 = 7'(1970 % 100);
    localparam logic [8:0] BASE_C400 = 9'(1970 % 400);

    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP = 9'd366;
    localparam logic [15:0] FEB_LAST_DOY = 16'd58;
    localparam logic [5:0] LAST_SUNDAY_MIN = 6'd25;
    localparam logic [4:0] SWITCH_HOUR = 5'd2;
    localparam logic [4:0] LAST_HOUR = 5'd23;
    localparam logic [2:0] LAST_WDAY = 3'd6;
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_OCT = 4'd10;
    localparam logic [3:0] LAST_MONTH_IDX = 4'd11;
    localparam logic [4:0] ZONE_RESET = 5'd1;
    localparam logic signed [12:0] SEC_PER_HOUR = 13'sd3600;

    // microcode opcodes
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_WAIT  = 4'd1;
    localparam logic [3:0] OP_DIV   = 4'd2;
    localparam logic [3:0] OP_COPY  = 4'd3;
    localparam logic [3:0] OP_YEAR  = 4'd4;
    localparam logic [3:0] OP_MADJ  = 4'd5;
    localparam logic [3:0] OP_MONTH = 4'd6;
    localparam logic [3:0] OP_FIN   = 4'd7;
    localparam logic [3:0] OP_DST   = 4'd8;
    localparam logic [3:0] OP_EMIT  = 4'd9;

    // divider destination
    localparam logic [1:0] DSEL_SEC  = 2'd0;
    localparam logic [1:0] DSEL_MIN  = 2'd1;
    localparam logic [1:0] DSEL_HOUR = 2'd2;
    localparam logic [1:0] DSEL_WDAY = 2'd3;

    // jump conditions
    localparam logic [2:0] COND_NEVER  = 3'd0;
    localparam logic [2:0] COND_ALWAYS = 3'd1;
    localparam logic [2:0] COND_NOIN   = 3'd2;
    localparam logic [2:0] COND_DIVRUN = 3'd3;
    localparam logic [2:0] COND_YMORE  = 3'd4;
    localparam logic [2:0] COND_MMORE  = 3'd5;
    localparam logic [2:0] COND_OBUSY  = 3'd6;

    // program steps
    localparam logic [PC_W-1:0] STEP_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] STEP_DSEC  = 4'd1;
    localparam logic [PC_W-1:0] STEP_DMIN  = 4'd2;
    localparam logic [PC_W-1:0] STEP_DHOUR = 4'd3;
    localparam logic [PC_W-1:0] STEP_COPY  = 4'd4;
    localparam logic [PC_W-1:0] STEP_DWDAY = 4'd5;
    localparam logic [PC_W-1:0] STEP_YEAR  = 4'd6;
    localparam logic [PC_W-1:0] STEP_MADJ  = 4'd7;
    localparam logic [PC_W-1:0] STEP_MONTH = 4'd8;
    localparam logic [PC_W-1:0] STEP_FIN   = 4'd9;
    localparam logic [PC_W-1:0] STEP_DST   = 4'd10;
    localparam logic [PC_W-1:0] STEP_EMIT  = 4'd11;
    localparam logic [PC_W-1:0] STEP_BACK  = 4'd12;

    typedef struct packed {
        logic [3:0]      op;
        logic [1:0]      dsel;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic no_in;
        logic div_run;
        logic y_more;
        logic m_more;
        logic o_busy;
    } status_t;

    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            STEP_WAIT:  w = '{OP_WAIT,  DSEL_SEC,  COND_NOIN,   STEP_WAIT};
            STEP_DSEC:  w = '{OP_DIV,   DSEL_SEC,  COND_DIVRUN, STEP_DSEC};
            STEP_DMIN:  w = '{OP_DIV,   DSEL_MIN,  COND_DIVRUN, STEP_DMIN};
            STEP_DHOUR: w = '{OP_DIV,   DSEL_HOUR, COND_DIVRUN, STEP_DHOUR};
            STEP_COPY:  w = '{OP_COPY,  DSEL_SEC,  COND_NEVER,  STEP_WAIT};
            STEP_DWDAY: w = '{OP_DIV,   DSEL_WDAY, COND_DIVRUN, STEP_DWDAY};
            STEP_YEAR:  w = '{OP_YEAR,  DSEL_SEC,  COND_YMORE,  STEP_YEAR};
            STEP_MADJ:  w = '{OP_MADJ,  DSEL_SEC,  COND_NEVER,  STEP_WAIT};
            STEP_MONTH: w = '{OP_MONTH, DSEL_SEC,  COND_MMORE,  STEP_MONTH};
            STEP_FIN:   w = '{OP_FIN,   DSEL_SEC,  COND_NEVER,  STEP_WAIT};
            STEP_DST:   w = '{OP_DST,   DSEL_SEC,  COND_NEVER,  STEP_WAIT};
            STEP_EMIT:  w = '{OP_EMIT,  DSEL_SEC,  COND_OBUSY,  STEP_EMIT};
            STEP_BACK:  w = '{OP_NOP,   DSEL_SEC,  COND_ALWAYS, STEP_WAIT};
            default:    w = '{OP_NOP,   DSEL_SEC,  COND_ALWAYS, STEP_WAIT};
        endcase
        return w;
    endfunction

    // month length by month number, 1 is January; leap February
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd1:    d = 5'd31;
            4'd2:    d = 5'd29;
            4'd3:    d = 5'd31;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd31;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd31;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd31;
            4'd11:   d = 5'd30;
            4'd12:   d = 5'd31;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    function automatic logic [5:0] divisor_of(input logic [1:0] dsel);
        logic [5:0] d;
        case (dsel)
            DSEL_SEC:  d = 6'd60;
            DSEL_MIN:  d = 6'd60;
            DSEL_HOUR: d = 6'd24;
            DSEL_WDAY: d = 6'd7;
            default:   d = 6'd60;
        endcase
        return d;
    endfunction

    // reciprocal and shift: quotient = (x * recip) >> shift
    // exact for any 32-bit x for 60 and 24, for x below 2^16 for 7
    function automatic logic [31:0] recip_of(input logic [1:0] dsel);
        logic [31:0] r;
        case (dsel)
            DSEL_SEC:  r = 32'h8888_8889;
            DSEL_MIN:  r = 32'h8888_8889;
            DSEL_HOUR: r = 32'hAAAA_AAAB;
            DSEL_WDAY: r = 32'd74899;
            default:   r = 32'h8888_8889;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] shift_of(input logic [1:0] dsel);
        logic [5:0] s;
        case (dsel)
            DSEL_SEC:  s = 6'd37;
            DSEL_MIN:  s = 6'd37;
            DSEL_HOUR: s = 6'd36;
            DSEL_WDAY: s = 6'd19;
            default:   s = 6'd37;
        endcase
        return s;
    endfunction

endpackage

FILE: sv/ecal_seq.sv
// Microcode sequencer: step counter and control store lookup.
// Depends on ecal_pkg.
module ecal_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  ecal_pkg::status_t status,
    output ecal_pkg::ctrl_t   ctrl
);

    logic [ecal_pkg::PC_W-1:0] pc_reg;
    logic [ecal_pkg::PC_W-1:0] pc_next;
    logic                      take;

    assign ctrl = ecal_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            ecal_pkg::COND_NEVER:  take = 1'b0;
            ecal_pkg::COND_ALWAYS: take = 1'b1;
            ecal_pkg::COND_NOIN:   take = status.no_in;
            ecal_pkg::COND_DIVRUN: take = status.div_run;
            ecal_pkg::COND_YMORE:  take = status.y_more;
            ecal_pkg::COND_MMORE:  take = status.m_more;
            ecal_pkg::COND_OBUSY:  take = status.o_busy;
            default:               take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ecal_pkg::STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: sv/epoch_to_local_calendar_dst_core.sv
// Top level of the epoch to local calendar converter with EU summer time.
// Depends on ecal_pkg, ecal_seq and assert_macros.svh.
//
// One item at a time: an input transfer starts a microcoded run whose length
// grows with Y, the number of years past the base year (0 to 136), and M, the
// month index walked (0 to 11). Each of the four divisions (seconds, minutes,
// hours, weekday) goes through a reciprocal multiply: the product is
// registered first, then quotient and remainder are taken from it. The year
// walk takes one cycle per year and the month walk one cycle per month.
// The run ends with the emit and return steps. The result sits in an output
// register, so the next input is taken while it waits; a new result waits in
// the emit step until the old one is taken. The zone offset register resets
// to +1 hour and takes a write every cycle.
`include "assert_macros.svh"

module epoch_to_local_calendar_dst_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,       // zone_offset_hours, signed
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // epoch_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // year, month, day, hour, minute, second,
                                        // weekday, dst_flag, zero fill
);

    ecal_pkg::ctrl_t   ctrl;
    ecal_pkg::status_t status;

    logic signed [4:0]  zone_reg;
    logic [31:0]        acc_reg, acc_next;
    logic [63:0]        prod_reg, prod_next;
    logic [ecal_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [15:0]        days_reg, days_next;
    logic [11:0]        year_reg, year_next;
    logic [6:0]         c100_reg, c100_next;
    logic [8:0]         c400_reg, c400_next;
    logic [3:0]         month_reg, month_next;
    logic [4:0]         hour_reg, hour_next;
    logic [5:0]         minute_reg, minute_next;
    logic [5:0]         second_reg, second_next;
    logic [2:0]         wday_reg, wday_next;
    logic               dst_reg, dst_next;
    logic               out_valid_reg, out_valid_next;
    logic [47:0]        out_data_reg, out_data_next;

    logic signed [16:0] offs_sec;
    logic [5:0]         divisor;
    logic [31:0]        recip;
    logic [5:0]         shamt;
    logic [31:0]        quot;
    logic [31:0]        rem_full;
    logic               leap;
    logic [8:0]         ylen;
    logic               in_season;
    logic               late;
    logic               after_switch;
    logic               summer;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (ctrl.op == ecal_pkg::OP_WAIT);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign offs_sec = 17'(zone_reg * ecal_pkg::SEC_PER_HOUR);

    // division by a constant: reciprocal product, then shift and remainder
    assign divisor  = ecal_pkg::divisor_of(ctrl.dsel);
    assign recip    = ecal_pkg::recip_of(ctrl.dsel);
    assign shamt    = ecal_pkg::shift_of(ctrl.dsel);
    assign quot     = 32'(prod_reg >> shamt);
    assign rem_full = acc_reg - 32'(quot * {26'd0, divisor});

    assign leap = (year_reg[1:0] == 2'd0) && ((c100_reg != 7'd0) || (c400_reg == 9'd0));
    assign ylen = leap ? ecal_pkg::DAYS_LEAP : ecal_pkg::DAYS_COMMON;

    // summer time compares local standard time
    assign in_season    = (month_reg >= ecal_pkg::MONTH_MAR) &&
                          (month_reg <= ecal_pkg::MONTH_OCT);
    assign late         = ({1'b0, days_reg[4:0]} >=
                           (6'(wday_reg) + ecal_pkg::LAST_SUNDAY_MIN));
    assign after_switch = late && ((wday_reg != 3'd0) || (hour_reg >= ecal_pkg::SWITCH_HOUR));
    assign summer       = in_season && (after_switch ? (month_reg != ecal_pkg::MONTH_OCT)
                                                     : (month_reg != ecal_pkg::MONTH_MAR));

    assign status.no_in   = !s_axis_tvalid;
    assign status.div_run = (div_cnt_reg != ecal_pkg::DIV_LAST);
    assign status.y_more  = (days_reg >= 16'(ylen));
    assign status.m_more  = (month_reg < ecal_pkg::LAST_MONTH_IDX) &&
                            (days_reg >= 16'(ecal_pkg::month_days(month_reg + 4'd1)));
    assign status.o_busy  = out_valid_reg && !m_axis_tready;

    ecal_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    always_comb
    begin
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        div_cnt_next   = div_cnt_reg;
        days_next      = days_reg;
        year_next      = year_reg;
        c100_next      = c100_reg;
        c400_next      = c400_reg;
        month_next     = month_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        wday_next      = wday_reg;
        dst_next       = dst_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        case (ctrl.op)
            ecal_pkg::OP_WAIT:
            begin
                if (s_axis_tvalid)
                begin
                    acc_next = s_axis_tdata + 32'(offs_sec);
                end
            end
            ecal_pkg::OP_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == ecal_pkg::DIV_LAST)
                begin
                    acc_next = quot;
                    case (ctrl.dsel)
                        ecal_pkg::DSEL_SEC:  second_next = rem_full[5:0];
                        ecal_pkg::DSEL_MIN:  minute_next = rem_full[5:0];
                        ecal_pkg::DSEL_HOUR: hour_next   = rem_full[4:0];
                        ecal_pkg::DSEL_WDAY: wday_next   = rem_full[2:0];
                        default:             second_next = rem_full[5:0];
                    endcase
                end
                else
                begin
                    prod_next = {32'd0, acc_reg} * {32'd0, recip};
                end
            end
            ecal_pkg::OP_COPY:
            begin
                days_next = acc_reg[15:0];
                acc_next  = acc_reg + ecal_pkg::BASE_WEEKDAY;
                year_next = ecal_pkg::BASE_YEAR;
                c100_next = ecal_pkg::BASE_C100;
                c400_next = ecal_pkg::BASE_C400;
                dst_next  = 1'b0;
            end
            ecal_pkg::OP_YEAR:
            begin
                if (status.y_more)
                begin
                    days_next = days_reg - 16'(ylen);
                    year_next = year_reg + 12'd1;
                    c100_next = (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                    c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                end
            end
            ecal_pkg::OP_MADJ:
            begin
                // common year: skip the Feb 29 slot of the table
                if (!leap && (days_reg > ecal_pkg::FEB_LAST_DOY))
                begin
                    days_next = days_reg + 16'd1;
                end
                month_next = 4'd0;
            end
            ecal_pkg::OP_MONTH:
            begin
                if (status.m_more)
                begin
                    days_next  = days_reg - 16'(ecal_pkg::month_days(month_reg + 4'd1));
                    month_next = month_reg + 4'd1;
                end
            end
            ecal_pkg::OP_FIN:
            begin
                days_next  = days_reg + 16'd1;
                month_next = month_reg + 4'd1;
            end
            ecal_pkg::OP_DST:
            begin
                if (summer)
                begin
                    dst_next = 1'b1;
                    if (hour_reg == ecal_pkg::LAST_HOUR)
                    begin
                        hour_next = 5'd0;
                        wday_next = (wday_reg == ecal_pkg::LAST_WDAY) ? 3'd0 : wday_reg + 3'd1;
                        if (days_reg[4:0] >= ecal_pkg::month_days(month_reg))
                        begin
                            days_next  = 16'd1;
                            month_next = month_reg + 4'd1;
                        end
                        else
                        begin
                            days_next = days_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        hour_next = hour_reg + 5'd1;
                    end
                end
            end
            ecal_pkg::OP_EMIT:
            begin
                if (!status.o_busy)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'd0, dst_reg, wday_reg + 3'd1, second_reg, minute_reg,
                                      hour_reg, days_reg[4:0], month_reg, year_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg      <= ecal_pkg::ZONE_RESET;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                zone_reg <= cfg_data;
            end
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        days_reg     <= days_next;
        year_reg     <= year_next;
        c100_reg     <= c100_next;
        c400_reg     <= c400_next;
        month_reg    <= month_next;
        hour_reg     <= hour_next;
        minute_reg   <= minute_next;
        second_reg   <= second_next;
        wday_reg     <= wday_next;
        dst_reg      <= dst_next;
        out_data_reg <= out_data_next;
    end

    `ECAL_ASSERT(a_div_fresh, s_axis_tvalid && s_axis_tready |=> div_cnt_reg == '0, "divider not idle at item start")
    `ECAL_ASSERT(a_emit_only, $rose(m_axis_tvalid) |-> $past(ctrl.op == ecal_pkg::OP_EMIT), "result raised outside emit step")
    `ECAL_ASSERT_NOT(a_month_range, m_axis_tvalid && (m_axis_tdata[15:12] == 4'd0 || m_axis_tdata[15:12] > 4'd12), "month out of range")

endmodule
